/* rtl/video_register_port_with_vram_defines.svh */
// assertion macros for the video register port
// used by video_register_port_with_vram.sv, needs clk and rst in scope
`ifndef VIDEO_REGISTER_PORT_WITH_VRAM_DEFINES_SVH
`define VIDEO_REGISTER_PORT_WITH_VRAM_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every clock outside reset
`define VRP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("vrp check failed");
// condition must never be true outside reset
`define VRP_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("vrp forbidden condition seen");
`else
`define VRP_ASSERT(label, prop)
`define VRP_NEVER(label, cond)
`endif

`endif

/* rtl/vrp_pkg.sv */
// types, codes and address helpers for the video register port
// no dependencies
package vrp_pkg;

  typedef struct packed {
    logic [2:0] func;
    logic [2:0] reg_index;
    logic [7:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        nmi_request;
    logic [15:0] vram_address;
    logic [2:0]  fine_x_scroll;
  } out_item_t;

  // item functions
  localparam logic [2:0] FUNC_READ      = 3'd0;
  localparam logic [2:0] FUNC_WRITE     = 3'd1;
  localparam logic [2:0] FUNC_VBLANK    = 3'd2;
  localparam logic [2:0] FUNC_PRERENDER = 3'd3;
  localparam logic [2:0] FUNC_STEP_X    = 3'd4;
  localparam logic [2:0] FUNC_STEP_Y    = 3'd5;
  localparam logic [2:0] FUNC_COPY_X    = 3'd6;
  localparam logic [2:0] FUNC_COPY_Y    = 3'd7;

  // cpu register numbers
  localparam logic [2:0] REG_CTRL     = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_OAM_ADDR = 3'd3;
  localparam logic [2:0] REG_OAM_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL   = 3'd5;
  localparam logic [2:0] REG_ADDR     = 3'd6;
  localparam logic [2:0] REG_DATA     = 3'd7;

  // nametable mirroring modes
  localparam logic [1:0] MIRROR_HORIZ    = 2'd0;
  localparam logic [1:0] MIRROR_VERT     = 2'd1;
  localparam logic [1:0] MIRROR_SINGLE_0 = 2'd2;
  localparam logic [1:0] MIRROR_SINGLE_1 = 2'd3;

  // memory sizes
  localparam int NT_DEPTH  = 2048;
  localparam int NT_AW     = 11;
  localparam int PAL_DEPTH = 32;
  localparam int PAL_AW    = 5;
  localparam int OAM_DEPTH = 256;
  localparam int OAM_AW    = 8;

  // palette and oam share one ram: oam in the low half, palette at the start of the upper half
  localparam int AUX_DEPTH = 512;
  localparam int AUX_AW    = 9;

  localparam logic [5:0]  PALETTE_PAGE = 6'h3F;
  localparam logic [7:0]  GRAY_MASK    = 8'h30;
  localparam logic [15:0] COPY_X_BITS  = 16'h041F;
  localparam logic [15:0] COPY_Y_BITS  = 16'h7BE0;
  localparam logic [15:0] FINE_Y_STEP  = 16'h1000;
  localparam logic [15:0] FINE_Y_BITS  = 16'h7000;
  localparam logic [15:0] NT_H_FLIP    = 16'h0400;
  localparam logic [15:0] NT_V_FLIP    = 16'h0800;

  // nametable ram address from a 14-bit video address
  function automatic logic [NT_AW-1:0] nt_index(input logic [1:0] mirr,
                                                 input logic [13:0] a);
    logic sel;
    begin
      case (mirr)
        MIRROR_VERT:     sel = a[10];
        MIRROR_SINGLE_0: sel = 1'b0;
        MIRROR_SINGLE_1: sel = 1'b1;
        default:         sel = a[11];
      endcase
      nt_index = {sel, a[9:0]};
    end
  endfunction

  // palette ram address, sprite backdrop entries fold onto background ones
  function automatic logic [PAL_AW-1:0] pal_index(input logic [13:0] a);
    logic [PAL_AW-1:0] p;
    begin
      p = a[PAL_AW-1:0];
      if (p[4] && (p[1:0] == 2'b00)) begin
        p[4] = 1'b0;
      end
      pal_index = p;
    end
  endfunction

  function automatic logic [15:0] step_x(input logic [15:0] a);
    begin
      if (a[4:0] == 5'd31) begin
        step_x = {a[15:5], 5'd0} ^ NT_H_FLIP;
      end else begin
        step_x = a + 16'd1;
      end
    end
  endfunction

  function automatic logic [15:0] step_y(input logic [15:0] a);
    logic [15:0] r;
    logic [4:0]  y;
    begin
      if ((a & FINE_Y_BITS) != FINE_Y_BITS) begin
        r = a + FINE_Y_STEP;
      end else begin
        r = a & ~FINE_Y_BITS;
        y = r[9:5];
        if (y == 5'd29) begin
          y = 5'd0;
          r = r ^ NT_V_FLIP;
        end else if (y == 5'd31) begin
          y = 5'd0;
        end else begin
          y = y + 5'd1;
        end
        r[9:5] = y;
      end
      step_y = r;
    end
  endfunction

endpackage

/* rtl/vrp_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module vrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/video_register_port_with_vram.sv */
// top level of the video register port: cpu registers, scroll latches, vram
// depends on vrp_pkg, vrp_ram and video_register_port_with_vram_defines.svh
//
//  channel | signals                         | item / meaning
//  --------+---------------------------------+-------------------------------
//  request | req_valid, req_stall, req       | bus access or renderer event
//  result  | rsp_valid, rsp_stall, rsp       | read byte, nmi, address, fine x
//  config  | cfg_wr_en, cfg_wr_data          | nametable mirroring mode
//
// in the accept cycle an item updates all registers but the read buffer and issues
// the one memory read or write; in the cycle after, the registered ram data loads the
// result register and the read buffer, and no new item is accepted until that is done
// after reset a clearing pass zeroes the memories, one nametable entry
// and one palette or oam entry per cycle
// a full result register held by rsp_stall keeps req_stall high
`include "video_register_port_with_vram_defines.svh"

module video_register_port_with_vram (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_wr_data,
  input  logic               req_valid,
  output logic               req_stall,
  input  vrp_pkg::in_item_t  req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output vrp_pkg::out_item_t rsp
);

  // read result sources for the s1 stage
  localparam logic [1:0] RD_NONE = 2'd0;
  localparam logic [1:0] RD_IMM  = 2'd1;
  localparam logic [1:0] RD_OAM  = 2'd2;
  localparam logic [1:0] RD_DATA = 2'd3;

  // where a data port read comes from
  localparam logic [1:0] SRC_PATTERN = 2'd0;
  localparam logic [1:0] SRC_NT      = 2'd1;
  localparam logic [1:0] SRC_PAL     = 2'd2;

  // architectural registers
  logic [1:0]  mirroring;
  logic [7:0]  control_reg, control_reg_next;
  logic [7:0]  mask_reg, mask_reg_next;
  logic        vblank_flag, vblank_flag_next;
  logic [7:0]  sprite_mem_addr, sprite_mem_addr_next;
  logic [15:0] current_addr, current_addr_next;
  logic [14:0] temp_addr, temp_addr_next;
  logic [2:0]  fine_x, fine_x_next;
  logic        write_toggle, write_toggle_next;
  logic [7:0]  read_buffer;

  // clearing pass
  logic                      clearing;
  logic [vrp_pkg::NT_AW-1:0] clear_cnt;

  // second stage
  logic        s1_valid;
  logic [1:0]  s1_rd_sel, rd_sel;
  logic [7:0]  s1_imm, imm;
  logic [1:0]  s1_src, src;
  logic        s1_gray;
  logic        s1_nmi, nmi;
  logic [15:0] s1_vram;
  logic [2:0]  s1_fine;

  logic        req_accept;
  logic        status_read;
  logic        rendering;
  logic [13:0] vaddr;
  logic [15:0] addr_inc;

  // memory ports
  logic                       nt_we, pal_we, oam_we, aux_oam;
  logic [vrp_pkg::NT_AW-1:0]  nt_addr;
  logic [vrp_pkg::PAL_AW-1:0] pal_addr;
  logic [vrp_pkg::AUX_AW-1:0] aux_addr;
  logic [7:0]                 nt_rdata, aux_rdata, mem_wdata;
  logic [7:0]                 fresh, pal_masked, rd_byte;

  assign req_stall  = clearing | s1_valid | (rsp_valid & rsp_stall);
  assign req_accept = req_valid & ~req_stall;

  assign status_read = req_accept && (req.func == vrp_pkg::FUNC_READ)
                    && (req.reg_index == vrp_pkg::REG_STATUS);

  assign rendering = mask_reg[4] | mask_reg[3];
  assign vaddr     = current_addr[13:0];
  assign addr_inc  = control_reg[2] ? 16'd32 : 16'd1;
  assign nt_addr   = vrp_pkg::nt_index(mirroring, vaddr);
  assign pal_addr  = vrp_pkg::pal_index(vaddr);
  assign mem_wdata = clearing ? 8'd0 : req.write_data;

  // oam data accesses use the low half of the shared ram, data port the palette
  assign aux_oam  = (req.reg_index == vrp_pkg::REG_OAM_DATA);
  assign aux_addr = aux_oam ? {1'b0, sprite_mem_addr} : {1'b1, 3'b000, pal_addr};

  // data port source: pattern space below 0x2000, palette page at the top
  always_comb begin
    if (!vaddr[13]) begin
      src = SRC_PATTERN;
    end else if (vaddr[13:8] == vrp_pkg::PALETTE_PAGE) begin
      src = SRC_PAL;
    end else begin
      src = SRC_NT;
    end
  end

  // all register updates of an item but the read buffer happen at its accept edge
  always_comb begin
    control_reg_next     = control_reg;
    mask_reg_next        = mask_reg;
    vblank_flag_next     = vblank_flag;
    sprite_mem_addr_next = sprite_mem_addr;
    current_addr_next    = current_addr;
    temp_addr_next       = temp_addr;
    fine_x_next          = fine_x;
    write_toggle_next    = write_toggle;
    nt_we                = 1'b0;
    pal_we               = 1'b0;
    oam_we               = 1'b0;
    rd_sel               = RD_NONE;
    imm                  = 8'd0;
    nmi                  = 1'b0;
    if (req_accept) begin
      case (req.func)
        vrp_pkg::FUNC_READ: begin
          case (req.reg_index)
            vrp_pkg::REG_STATUS: begin
              rd_sel            = RD_IMM;
              imm               = {vblank_flag, 2'b00, read_buffer[4:0]};
              vblank_flag_next  = 1'b0;
              write_toggle_next = 1'b0;
            end
            vrp_pkg::REG_OAM_DATA: begin
              rd_sel = RD_OAM;
            end
            vrp_pkg::REG_DATA: begin
              rd_sel            = RD_DATA;
              current_addr_next = current_addr + addr_inc;
            end
            default: begin
            end
          endcase
        end
        vrp_pkg::FUNC_WRITE: begin
          case (req.reg_index)
            vrp_pkg::REG_CTRL: begin
              control_reg_next = req.write_data;
              temp_addr_next   = {temp_addr[14:12], req.write_data[1:0], temp_addr[9:0]};
            end
            vrp_pkg::REG_MASK: begin
              mask_reg_next = req.write_data;
            end
            vrp_pkg::REG_OAM_ADDR: begin
              sprite_mem_addr_next = req.write_data;
            end
            vrp_pkg::REG_OAM_DATA: begin
              oam_we               = 1'b1;
              sprite_mem_addr_next = sprite_mem_addr + 8'd1;
            end
            vrp_pkg::REG_SCROLL: begin
              if (!write_toggle) begin
                fine_x_next       = req.write_data[2:0];
                temp_addr_next    = {temp_addr[14:5], req.write_data[7:3]};
                write_toggle_next = 1'b1;
              end else begin
                // fine y in 14:12, coarse y in 9:5
                temp_addr_next    = {req.write_data[2:0], temp_addr[11:10],
                                     req.write_data[7:3], temp_addr[4:0]};
                write_toggle_next = 1'b0;
              end
            end
            vrp_pkg::REG_ADDR: begin
              if (!write_toggle) begin
                temp_addr_next    = {1'b0, req.write_data[5:0], temp_addr[7:0]};
                write_toggle_next = 1'b1;
              end else begin
                temp_addr_next    = {temp_addr[14:8], req.write_data};
                current_addr_next = {1'b0, temp_addr[14:8], req.write_data};
                write_toggle_next = 1'b0;
              end
            end
            vrp_pkg::REG_DATA: begin
              nt_we             = (src == SRC_NT);
              pal_we            = (src == SRC_PAL);
              current_addr_next = current_addr + addr_inc;
            end
            default: begin
            end
          endcase
        end
        vrp_pkg::FUNC_VBLANK: begin
          vblank_flag_next = 1'b1;
          nmi              = control_reg[7];
        end
        vrp_pkg::FUNC_PRERENDER: begin
          vblank_flag_next = 1'b0;
        end
        vrp_pkg::FUNC_STEP_X: begin
          if (rendering) begin
            current_addr_next = vrp_pkg::step_x(current_addr);
          end
        end
        vrp_pkg::FUNC_STEP_Y: begin
          if (rendering) begin
            current_addr_next = vrp_pkg::step_y(current_addr);
          end
        end
        vrp_pkg::FUNC_COPY_X: begin
          if (rendering) begin
            current_addr_next = (current_addr & ~vrp_pkg::COPY_X_BITS)
                              | ({1'b0, temp_addr} & vrp_pkg::COPY_X_BITS);
          end
        end
        default: begin
          if (rendering) begin
            current_addr_next = (current_addr & ~vrp_pkg::COPY_Y_BITS)
                              | ({1'b0, temp_addr} & vrp_pkg::COPY_Y_BITS);
          end
        end
      endcase
    end
  end

  // nametables in one ram, palette and oam share the other;
  // the clearing pass shares the write ports
  vrp_ram #(
    .WIDTH(8),
    .DEPTH(vrp_pkg::NT_DEPTH)
  ) u_nt_ram (
    .clk     (clk),
    .wr_en   (clearing | nt_we),
    .wr_addr (clearing ? clear_cnt : nt_addr),
    .wr_data (mem_wdata),
    .rd_en   (req_accept),
    .rd_addr (nt_addr),
    .rd_data (nt_rdata)
  );

  vrp_ram #(
    .WIDTH(8),
    .DEPTH(vrp_pkg::AUX_DEPTH)
  ) u_aux_ram (
    .clk     (clk),
    .wr_en   (clearing | pal_we | oam_we),
    .wr_addr (clearing ? clear_cnt[vrp_pkg::AUX_AW-1:0] : aux_addr),
    .wr_data (mem_wdata),
    .rd_en   (req_accept),
    .rd_addr (aux_addr),
    .rd_data (aux_rdata)
  );

  // s1 stage: fresh memory byte and the byte handed back
  assign pal_masked = s1_gray ? (aux_rdata & vrp_pkg::GRAY_MASK) : aux_rdata;

  always_comb begin
    case (s1_src)
      SRC_NT:  fresh = nt_rdata;
      SRC_PAL: fresh = pal_masked;
      default: fresh = 8'd0;
    endcase
  end

  always_comb begin
    case (s1_rd_sel)
      RD_IMM:  rd_byte = s1_imm;
      RD_OAM:  rd_byte = aux_rdata;
      // palette reads skip the buffer delay
      RD_DATA: rd_byte = (s1_src == SRC_PAL) ? fresh : read_buffer;
      default: rd_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mirroring       <= vrp_pkg::MIRROR_HORIZ;
      control_reg     <= 8'd0;
      mask_reg        <= 8'd0;
      vblank_flag     <= 1'b0;
      sprite_mem_addr <= 8'd0;
      current_addr    <= 16'd0;
      temp_addr       <= 15'd0;
      fine_x          <= 3'd0;
      write_toggle    <= 1'b0;
      read_buffer     <= 8'd0;
      clearing        <= 1'b1;
      clear_cnt       <= '0;
      s1_valid        <= 1'b0;
      rsp_valid       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mirroring <= cfg_wr_data;
      end
      control_reg     <= control_reg_next;
      mask_reg        <= mask_reg_next;
      vblank_flag     <= vblank_flag_next;
      sprite_mem_addr <= sprite_mem_addr_next;
      current_addr    <= current_addr_next;
      temp_addr       <= temp_addr_next;
      fine_x          <= fine_x_next;
      write_toggle    <= write_toggle_next;

      if (clearing) begin
        clear_cnt <= clear_cnt + 1'b1;
        if (clear_cnt == vrp_pkg::NT_AW'(vrp_pkg::NT_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end

      if (s1_valid && (s1_rd_sel == RD_DATA)) begin
        read_buffer <= fresh;
      end

      s1_valid <= req_accept;

      // the result register is always empty when an item reaches the s1 stage
      if (s1_valid) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_accept) begin
      s1_rd_sel <= rd_sel;
      s1_imm    <= imm;
      s1_src    <= src;
      s1_gray   <= mask_reg[0];
      s1_nmi    <= nmi;
      s1_vram   <= current_addr_next;
      s1_fine   <= fine_x_next;
    end
    if (s1_valid) begin
      rsp.read_data     <= rd_byte;
      rsp.nmi_request   <= s1_nmi;
      rsp.vram_address  <= s1_vram;
      rsp.fine_x_scroll <= s1_fine;
    end
  end

  `VRP_NEVER(a_no_accept_while_clearing, clearing && req_accept)
  `VRP_NEVER(a_one_item_in_flight, s1_valid && req_accept)
  `VRP_ASSERT(a_result_follows_stage, $rose(rsp_valid) |-> $past(s1_valid))
  `VRP_ASSERT(a_status_read_clears, status_read |=> (!vblank_flag && !write_toggle))

endmodule
